[hw/rtl/slew_limited_two_axis_tracker_defines.svh]
// ----------------------------------------------------------------------------
// Slew-limited two-axis tracker: assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLEW_LIMITED_TWO_AXIS_TRACKER_DEFINES_SVH
`define SLEW_LIMITED_TWO_AXIS_TRACKER_DEFINES_SVH

// same-cycle implication
`define SLTA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slta assertion failed");

// next-cycle implication
`define SLTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slta assertion failed");

`endif

[hw/rtl/slta_pkg.sv]
// ----------------------------------------------------------------------------
// Slew-limited two-axis tracker package
// Beat types, register indexes, reset values and saturation helper.
// ----------------------------------------------------------------------------
package slta_pkg;

  typedef enum logic [1:0] {
    ST_NOT_REACHED = 2'd0,
    ST_REACHED     = 2'd1,
    ST_CANT_REACH  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_YAW_STEP   = 3'd0,
    CFG_PITCH_STEP = 3'd1,
    CFG_YAW_MIN    = 3'd2,
    CFG_YAW_MAX    = 3'd3,
    CFG_PITCH_MIN  = 3'd4,
    CFG_PITCH_MAX  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              command;
    logic signed [15:0] target_yaw;
    logic signed [15:0] target_pitch;
    logic [12:0]       blend;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic signed [15:0] yaw_out;
    logic signed [15:0] pitch_out;
  } out_t;

  typedef struct packed {
    logic [14:0]        step;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } axis_cfg_t;

  typedef struct packed {
    logic snap;
    logic clamp;
  } axis_flags_t;

  localparam logic [14:0]        YawStepRst  = 15'd410;
  localparam logic [14:0]        PitchStepRst = 15'd410;
  localparam logic signed [15:0] YawMinRst   = -16'sd12868;
  localparam logic signed [15:0] YawMaxRst   = 16'sd12868;
  localparam logic signed [15:0] PitchMinRst = -16'sd6434;
  localparam logic signed [15:0] PitchMaxRst = 16'sd6434;

  // blend above 0.9 in Q1.12
  localparam logic [12:0] BlendReachedMin = 13'd3687;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/slew_limited_two_axis_tracker.sv]
// ----------------------------------------------------------------------------
// Slew-limited two-axis tracker
// Holds yaw and pitch (Q3.12 rad); steps or blends them toward a target and
// clamps each to its limits, reporting reached / not reached / cannot reach.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: valid/ready beat of slta_pkg::in_t (command, targets, blend).
//   out channel: valid/ready beat of slta_pkg::out_t, one per input beat,
//                in order.
//   cfg channel: valid/ready write of a register index and data; always ready.
//                Write only while no beat is in flight.
//   An accepted beat sits in the input register; the update of both axes is
//   computed combinationally from it and the held angles and lands in the
//   output register. Throughput is one beat per cycle while the out
//   channel is not stalled; the angle registers feed back through the
//   combinational update.
//   A stalled out channel holds its beat; the input register still takes one
//   more beat, then in_ready_o drops until the output is taken.
//   Reset (rst_ni low, async) clears both angles to zero, empties both
//   registers and loads the default steps and limits.
// ----------------------------------------------------------------------------
`include "slew_limited_two_axis_tracker_defines.svh"

module slew_limited_two_axis_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  slta_pkg::in_t         in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output slta_pkg::out_t        out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  slta_pkg::axis_cfg_t   yaw_cfg_q, pitch_cfg_q;
  slta_pkg::in_t         in_q;
  logic                  in_valid_q;
  slta_pkg::out_t        out_q, out_d;
  logic                  out_valid_q;
  logic signed [15:0]    cur_yaw_q, cur_pitch_q;
  logic signed [15:0]    yaw_next, pitch_next;
  slta_pkg::axis_flags_t yaw_flags, pitch_flags;
  logic                  advance;

  assign advance     = in_valid_q && (out_ready_i || !out_valid_q);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  slta_axis u_yaw (
    .command_i (in_q.command),
    .cur_i     (cur_yaw_q),
    .tgt_i     (in_q.target_yaw),
    .blend_i   (in_q.blend),
    .cfg_i     (yaw_cfg_q),
    .next_o    (yaw_next),
    .flags_o   (yaw_flags)
  );

  slta_axis u_pitch (
    .command_i (in_q.command),
    .cur_i     (cur_pitch_q),
    .tgt_i     (in_q.target_pitch),
    .blend_i   (in_q.blend),
    .cfg_i     (pitch_cfg_q),
    .next_o    (pitch_next),
    .flags_o   (pitch_flags)
  );

  always_comb begin
    out_d.yaw_out   = yaw_next;
    out_d.pitch_out = pitch_next;
    if (in_q.command) begin
      if (yaw_flags.clamp || pitch_flags.clamp) begin
        out_d.status = slta_pkg::ST_CANT_REACH;
      end else if (in_q.blend >= slta_pkg::BlendReachedMin) begin
        out_d.status = slta_pkg::ST_REACHED;
      end else begin
        out_d.status = slta_pkg::ST_NOT_REACHED;
      end
    end else begin
      // a moving pitch overrides the yaw result
      if (pitch_flags.clamp) begin
        out_d.status = slta_pkg::ST_CANT_REACH;
      end else if (!pitch_flags.snap) begin
        out_d.status = slta_pkg::ST_NOT_REACHED;
      end else if (yaw_flags.clamp) begin
        out_d.status = slta_pkg::ST_CANT_REACH;
      end else if (yaw_flags.snap) begin
        out_d.status = slta_pkg::ST_REACHED;
      end else begin
        out_d.status = slta_pkg::ST_NOT_REACHED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_cfg_q.step   <= slta_pkg::YawStepRst;
      yaw_cfg_q.lo     <= slta_pkg::YawMinRst;
      yaw_cfg_q.hi     <= slta_pkg::YawMaxRst;
      pitch_cfg_q.step <= slta_pkg::PitchStepRst;
      pitch_cfg_q.lo   <= slta_pkg::PitchMinRst;
      pitch_cfg_q.hi   <= slta_pkg::PitchMaxRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        slta_pkg::CFG_YAW_STEP:   yaw_cfg_q.step   <= cfg_data_i[14:0];
        slta_pkg::CFG_PITCH_STEP: pitch_cfg_q.step <= cfg_data_i[14:0];
        slta_pkg::CFG_YAW_MIN:    yaw_cfg_q.lo     <= cfg_data_i;
        slta_pkg::CFG_YAW_MAX:    yaw_cfg_q.hi     <= cfg_data_i;
        slta_pkg::CFG_PITCH_MIN:  pitch_cfg_q.lo   <= cfg_data_i;
        slta_pkg::CFG_PITCH_MAX:  pitch_cfg_q.hi   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_yaw_q   <= '0;
      cur_pitch_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cur_yaw_q   <= yaw_next;
        cur_pitch_q <= pitch_next;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  `SLTA_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
  `SLTA_ASSERT_NEXT(a_state_matches_out, advance,
                    cur_yaw_q == out_q.yaw_out && cur_pitch_q == out_q.pitch_out)
  `SLTA_ASSERT_IMPL(a_stall_cause, !in_ready_o,
                    in_valid_q && out_valid_q && !out_ready_i)

endmodule

[hw/rtl/slta_axis.sv]
// ----------------------------------------------------------------------------
// Slew-limited tracker: one axis
// Step or blend update of one angle followed by the limit clamp.
// ----------------------------------------------------------------------------
module slta_axis (
  input  logic                   command_i,
  input  logic signed [15:0]     cur_i,
  input  logic signed [15:0]     tgt_i,
  input  logic [12:0]            blend_i,
  input  slta_pkg::axis_cfg_t    cfg_i,
  output logic signed [15:0]     next_o,
  output slta_pkg::axis_flags_t  flags_o
);

  logic signed [16:0] diff;
  logic [16:0]        abs_diff;
  logic               snap;
  logic [17:0]        cur_x;
  logic [17:0]        step_x;
  logic [17:0]        slew_sum;
  logic signed [15:0] slewed;
  logic signed [29:0] prod;
  logic signed [15:0] scaled;
  logic signed [15:0] pre;

  assign diff     = $signed({cur_i[15], cur_i}) - $signed({tgt_i[15], tgt_i});
  assign abs_diff = diff[16] ? 17'(~diff + 17'sd1) : 17'(diff);
  assign snap     = abs_diff < {2'b00, cfg_i.step};

  assign cur_x    = {{2{cur_i[15]}}, cur_i};
  assign step_x   = {3'b000, cfg_i.step};
  assign slew_sum = (cur_i > tgt_i) ? (cur_x - step_x) : (cur_x + step_x);
  assign slewed   = snap ? tgt_i : slta_pkg::sat16($signed(slew_sum));

  // floor(tgt * blend / 4096) is an arithmetic shift of the product
  assign prod   = tgt_i * $signed({1'b0, blend_i});
  assign scaled = slta_pkg::sat16($signed(prod[29:12]));

  assign pre = command_i ? scaled : slewed;

  always_comb begin
    next_o        = pre;
    flags_o.snap  = snap;
    flags_o.clamp = 1'b0;
    if (pre < cfg_i.lo) begin
      next_o        = cfg_i.lo;
      flags_o.clamp = 1'b1;
    end else if (pre > cfg_i.hi) begin
      next_o        = cfg_i.hi;
      flags_o.clamp = 1'b1;
    end
  end

endmodule
